[rtl/kocnt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package kocnt_pkg;

    localparam int MAX_WORD_LEN = 100;
    localparam int NUM_KEYS     = 11;
    localparam int KEY_CHARS    = 8;

    localparam int CHAR_W    = 8;
    localparam int LEN_W     = 7;
    localparam int KEY_IDX_W = 4;
    localparam int COUNT_W   = 16;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_WORD_LEN);

    // Keyword text, first character in the top byte, padded with zero bytes.
    localparam logic [KEY_CHARS*CHAR_W-1:0] KEY_TEXT [NUM_KEYS] = '{
        {"auto",     32'h0},
        {"break",    24'h0},
        {"case",     32'h0},
        {"char",     32'h0},
        {"const",    24'h0},
        {"continue"       },
        {"default",   8'h0},
        {"unsigned"       },
        {"void",     32'h0},
        {"volatile"       },
        {"while",    24'h0}
    };

    localparam logic [LEN_W-1:0] KEY_LEN [NUM_KEYS] = '{
        LEN_W'(4), LEN_W'(5), LEN_W'(4), LEN_W'(4), LEN_W'(5), LEN_W'(8),
        LEN_W'(7), LEN_W'(8), LEN_W'(4), LEN_W'(8), LEN_W'(5)
    };

    typedef logic [CHAR_W-1:0] char_t;

    // One queue entry: an optional counter increment, optionally followed by a report.
    typedef struct packed {
        logic                 report;
        logic                 hit;
        logic [KEY_IDX_W-1:0] key;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_REPORT = 2'b10
    } back_state_t;

endpackage

`default_nettype wire

[rtl/kocnt_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface kocnt_in_if;
    import kocnt_pkg::*;

    logic                valid;
    logic                ready;
    logic [CHAR_W-1:0]   ch;
    logic                end_of_input;

    modport source (output valid, output ch, output end_of_input, input ready);
    modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

`default_nettype wire

[rtl/kocnt_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface kocnt_out_if;
    import kocnt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [KEY_IDX_W-1:0] key_index;
    logic [COUNT_W-1:0]   key_count;
    logic                 last;

    modport source (output valid, output key_index, output key_count, output last,
                    input ready);
    modport sink   (input valid, input key_index, input key_count, input last,
                    output ready);
endinterface

`default_nettype wire

[rtl/keyword_occurrence_counter_top.sv]
// Keyword occurrence counter. Text bytes enter on the text channel, one transfer per cycle
// while the four-entry command queue has room; a byte with end_of_input set closes any open
// word and requests a report. Words are matched against the eleven keywords in the cycle
// that ends them; a match, a report request, or both from one byte take one queue entry, which
// the counter side retires while no report is running. A report walks the eleven counters one
// per cycle while the report channel is not stalled, and it emits one transfer per nonzero
// counter in table order with last set on the final one. Words longer than MAX_WORD_LEN
// characters are split, and counters saturate at 65535.
`timescale 1ns / 1ps
`default_nettype none

module keyword_occurrence_counter_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    kocnt_in_if.sink    text,
    kocnt_out_if.source report
);
    import kocnt_pkg::*;

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    cmd_t push_cmd;
    cmd_t head_cmd;

    kocnt_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (push_cmd)
    );

    kocnt_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty)
    );

    kocnt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_cmd (head_cmd),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .report   (report)
    );

endmodule

`default_nettype wire

[rtl/kocnt_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module kocnt_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    kocnt_in_if.sink           text,
    input  wire logic          q_full,
    output logic               q_push,
    output kocnt_pkg::cmd_t    q_cmd
);
    import kocnt_pkg::*;

    logic             in_word_reg,  in_word_next;
    logic [LEN_W-1:0] len_reg,      len_next;
    logic             too_long_reg, too_long_next;
    char_t            chars_reg [KEY_CHARS];
    char_t            chars_next [KEY_CHARS];

    logic             accept;
    logic             is_letter;
    logic             is_digit;
    logic             add;
    logic             close_now;
    logic             cand_in_word;
    logic             cand_too_long;
    logic [LEN_W-1:0] cand_len;
    char_t            cand_chars [KEY_CHARS];
    logic             match;
    logic [KEY_IDX_W-1:0] match_key;

    assign text.ready = !q_full;
    assign accept     = text.valid && text.ready;

    assign is_letter = (text.ch >= "A" && text.ch <= "Z") || (text.ch >= "a" && text.ch <= "z");
    assign is_digit  = (text.ch >= "0" && text.ch <= "9");

    always_comb
    begin
        add = 1'b0;
        if (!text.end_of_input)
        begin
            add = in_word_reg ? (is_letter || is_digit) : is_letter;
        end

        cand_in_word  = in_word_reg || add;
        cand_len      = add ? len_reg + LEN_W'(1) : len_reg;
        cand_too_long = too_long_reg || (add && (len_reg >= LEN_W'(KEY_CHARS)));
        for (int i = 0; i < KEY_CHARS; i++)
        begin
            cand_chars[i] = chars_reg[i];
            if (add && (len_reg == LEN_W'(i)))
            begin
                cand_chars[i] = text.ch;
            end
        end

        close_now = text.end_of_input
                 || (in_word_reg && !(is_letter || is_digit))
                 || (add && (cand_len >= MAX_LEN));
    end

    always_comb
    begin
        logic eq;
        match     = 1'b0;
        match_key = '0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            eq = (cand_len == KEY_LEN[k]);
            for (int i = 0; i < KEY_CHARS; i++)
            begin
                if (cand_chars[i] != KEY_TEXT[k][(KEY_CHARS-1-i)*CHAR_W +: CHAR_W])
                begin
                    eq = 1'b0;
                end
            end
            if (eq && !match)
            begin
                match     = 1'b1;
                match_key = KEY_IDX_W'(k);
            end
        end
    end

    always_comb
    begin
        q_cmd.report = text.end_of_input;
        q_cmd.hit    = close_now && cand_in_word && !cand_too_long && match;
        q_cmd.key    = match_key;
        q_push       = accept && (q_cmd.report || q_cmd.hit);
    end

    always_comb
    begin
        in_word_next  = in_word_reg;
        len_next      = len_reg;
        too_long_next = too_long_reg;
        chars_next    = chars_reg;
        if (accept)
        begin
            if (close_now)
            begin
                in_word_next  = 1'b0;
                len_next      = '0;
                too_long_next = 1'b0;
                for (int i = 0; i < KEY_CHARS; i++)
                begin
                    chars_next[i] = '0;
                end
            end
            else if (add)
            begin
                in_word_next  = 1'b1;
                len_next      = cand_len;
                too_long_next = cand_too_long;
                chars_next    = cand_chars;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_word_reg  <= 1'b0;
            len_reg      <= '0;
            too_long_reg <= 1'b0;
            for (int i = 0; i < KEY_CHARS; i++)
            begin
                chars_reg[i] <= '0;
            end
        end
        else
        begin
            in_word_reg  <= in_word_next;
            len_reg      <= len_next;
            too_long_reg <= too_long_next;
            chars_reg    <= chars_next;
        end
    end

endmodule

`default_nettype wire

[rtl/kocnt_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module kocnt_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire kocnt_pkg::cmd_t  push_cmd,
    output logic                  full,
    input  wire logic             pop,
    output kocnt_pkg::cmd_t       head_cmd,
    output logic                  empty
);
    import kocnt_pkg::*;

    cmd_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_AW:0] wptr_reg, wptr_next;
    logic [FIFO_AW:0] rptr_reg, rptr_next;

    assign empty    = (wptr_reg == rptr_reg);
    assign full     = (wptr_reg[FIFO_AW] != rptr_reg[FIFO_AW])
                   && (wptr_reg[FIFO_AW-1:0] == rptr_reg[FIFO_AW-1:0]);
    assign head_cmd = mem_reg[rptr_reg[FIFO_AW-1:0]];

    assign wptr_next = wptr_reg + (FIFO_AW+1)'(push);
    assign rptr_next = rptr_reg + (FIFO_AW+1)'(pop);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg[FIFO_AW-1:0]] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
        end
    end

    // The front only pushes while there is room, the back only pops what is there.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("queue underflow");

endmodule

`default_nettype wire

[rtl/kocnt_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module kocnt_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire kocnt_pkg::cmd_t  head_cmd,
    input  wire logic             q_empty,
    output logic                  q_pop,
    kocnt_out_if.source           report
);
    import kocnt_pkg::*;

    back_state_t          state_reg, state_next;
    logic [KEY_IDX_W-1:0] idx_reg,   idx_next;
    logic [COUNT_W-1:0]   cnt_reg [NUM_KEYS];
    logic [COUNT_W-1:0]   cnt_next [NUM_KEYS];

    logic                 out_valid_reg, out_valid_next;
    logic [KEY_IDX_W-1:0] out_key_reg,   out_key_next;
    logic [COUNT_W-1:0]   out_cnt_reg,   out_cnt_next;
    logic                 out_last_reg,  out_last_next;

    logic [NUM_KEYS-1:0]  nonzero;
    logic                 above;
    logic                 slot_free;
    logic                 step;

    assign report.valid     = out_valid_reg;
    assign report.key_index = out_key_reg;
    assign report.key_count = out_cnt_reg;
    assign report.last      = out_last_reg;

    assign slot_free = !out_valid_reg || report.ready;
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign step      = (state_reg == ST_REPORT) && slot_free;

    always_comb
    begin
        above = 1'b0;
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            nonzero[k] = (cnt_reg[k] != '0);
            if (nonzero[k] && (KEY_IDX_W'(k) > idx_reg))
            begin
                above = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !report.ready;
        out_key_next   = out_key_reg;
        out_cnt_next   = out_cnt_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    for (int k = 0; k < NUM_KEYS; k++)
                    begin
                        if (head_cmd.hit && (head_cmd.key == KEY_IDX_W'(k))
                            && (cnt_reg[k] != '1))
                        begin
                            cnt_next[k] = cnt_reg[k] + COUNT_W'(1);
                        end
                    end
                    if (head_cmd.report)
                    begin
                        state_next = ST_REPORT;
                        idx_next   = '0;
                    end
                end
            end
            ST_REPORT:
            begin
                if (step)
                begin
                    if (cnt_reg[idx_reg] != '0)
                    begin
                        out_valid_next = 1'b1;
                        out_key_next   = idx_reg;
                        out_cnt_next   = cnt_reg[idx_reg];
                        out_last_next  = !above;
                    end
                    for (int k = 0; k < NUM_KEYS; k++)
                    begin
                        if (idx_reg == KEY_IDX_W'(k))
                        begin
                            cnt_next[k] = '0;
                        end
                    end
                    if (idx_reg == KEY_IDX_W'(NUM_KEYS - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + KEY_IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_key_reg  <= out_key_next;
        out_cnt_reg  <= out_cnt_next;
        out_last_reg <= out_last_next;
    end

    // A finished report leaves every counter cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REPORT && state_next == ST_IDLE) |=> (nonzero == '0))
        else $error("counters not cleared after report");
    assert property (@(posedge clk) disable iff (!rst_n)
        report.valid |-> (report.key_count != '0))
        else $error("zero count reported");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REPORT) |-> (idx_reg <= KEY_IDX_W'(NUM_KEYS - 1)))
        else $error("report index out of range");

endmodule

`default_nettype wire

[sim/kocnt_checker.sv]
`timescale 1ns / 1ps

module kocnt_checker (
    input  logic clk,
    input  logic rst_n,
    kocnt_in_if  text,
    kocnt_out_if report,
    input  logic drained,
    output int   mismatches,
    output int   pending,
    output int   checked
);
    import kocnt_pkg::*;

    localparam logic [6:0] WORD_LIMIT = 7'(MAX_WORD_LEN);

    typedef struct packed {
        logic [KEY_IDX_W-1:0] key_index;
        logic [COUNT_W-1:0]   key_count;
        logic                 last;
    } kw_report_t;

    string keyword_text [NUM_KEYS] = '{
        "auto", "break", "case", "char", "const", "continue",
        "default", "unsigned", "void", "volatile", "while"
    };

    logic               wd_open;
    logic [6:0]         wd_len;
    logic [7:0]         wd_chars [8];
    logic               wd_long;
    logic [COUNT_W-1:0] kw_tally [NUM_KEYS];
    kw_report_t         expected_reports [$];
    logic               drain_seen;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    task automatic log_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic clear_word();
        wd_open = 1'b0;
        wd_len  = '0;
        wd_long = 1'b0;
        for (int i = 0; i < 8; i++)
        begin
            wd_chars[i] = '0;
        end
    endtask

    task automatic finish_word();
        logic same;
        logic found;
        found = 1'b0;
        if (wd_open && !wd_long)
        begin
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                same = !found && (keyword_text[k].len() == int'(wd_len));
                for (int i = 0; i < 8; i++)
                begin
                    if (same && i < keyword_text[k].len() && keyword_text[k][i] != wd_chars[i])
                        same = 1'b0;
                end
                if (same)
                begin
                    found = 1'b1;
                    if (kw_tally[k] != 16'hFFFF)
                        kw_tally[k]++;
                end
            end
        end
        clear_word();
    endtask

    task automatic take_char(input logic [7:0] c);
        if (wd_len < 7'd8)
            wd_chars[wd_len[2:0]] = c;
        else
            wd_long = 1'b1;
        wd_len = wd_len + 7'd1;
        if (wd_len >= WORD_LIMIT)
            finish_word();
    endtask

    task automatic predict_transfer(input logic [7:0] c, input logic eoi);
        kw_report_t r;
        int         last_k;
        if (eoi)
        begin
            finish_word();
            last_k = -1;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                if (kw_tally[k] != 0)
                    last_k = k;
            end
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                if (kw_tally[k] != 0)
                begin
                    r.key_index = KEY_IDX_W'(k);
                    r.key_count = kw_tally[k];
                    r.last      = (k == last_k);
                    expected_reports.push_back(r);
                end
                kw_tally[k] = '0;
            end
        end
        else if (wd_open)
        begin
            if (is_alpha(c) || is_num(c))
                take_char(c);
            else
                finish_word();
        end
        else if (is_alpha(c))
        begin
            wd_open = 1'b1;
            take_char(c);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        kw_report_t exp_r;
        if (!rst_n)
        begin
            clear_word();
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                kw_tally[k] = '0;
            end
            expected_reports.delete();
            mismatches = 0;
            checked    = 0;
            drain_seen = 1'b0;
        end
        else
        begin
            if (text.valid && text.ready)
                predict_transfer(text.ch, text.end_of_input);
            if (report.valid && report.ready)
            begin
                checked++;
                if (expected_reports.size() == 0)
                begin
                    log_mismatch($sformatf("unexpected report transfer key %0d count %0d last %0b",
                                           report.key_index, report.key_count, report.last));
                end
                else
                begin
                    exp_r = expected_reports.pop_front();
                    if (report.key_index !== exp_r.key_index ||
                        report.key_count !== exp_r.key_count ||
                        report.last !== exp_r.last)
                    begin
                        log_mismatch($sformatf({"key %0d count %0d last %0b, ",
                                                "predicted key %0d count %0d last %0b"},
                                               report.key_index, report.key_count, report.last,
                                               exp_r.key_index, exp_r.key_count, exp_r.last));
                    end
                end
            end
            if (drained && !drain_seen)
            begin
                drain_seen = 1'b1;
                if (expected_reports.size() != 0)
                    log_mismatch($sformatf("%0d report transfers never arrived",
                                           expected_reports.size()));
            end
        end
        pending = expected_reports.size();
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
    import kocnt_pkg::*;

    localparam int ITEMS_PER_PHASE = 60;

    logic clk;
    logic rst_n;
    logic drained;
    int   mismatches;
    int   pending;
    int   checked;
    int   idle_pct;
    int   stall_pct;
    int   bytes_sent;
    int   markers_sent;
    int   phase_items;

    string keyword_list [NUM_KEYS] = '{
        "auto", "break", "case", "char", "const", "continue",
        "default", "unsigned", "void", "volatile", "while"
    };
    logic [7:0] directed_seps [10] = '{
        8'h20, 8'h09, 8'h28, 8'h29, 8'h2C, 8'h3B, 8'h80, 8'hFF, 8'h00, 8'h7F
    };
    int idle_plan  [4] = '{0, 52, 0, 38};
    int stall_plan [4] = '{0, 0, 52, 38};

    kocnt_in_if  text_ch ();
    kocnt_out_if report_ch ();

    keyword_occurrence_counter_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .report (report_ch)
    );

    kocnt_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text_ch),
        .report     (report_ch),
        .drained    (drained),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        report_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            report_ch.ready <= rst_n && ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [7:0] random_letter();
        int n;
        n = $urandom_range(51);
        return (n < 26) ? 8'h41 + 8'(n) : 8'h61 + 8'(n - 26);
    endfunction

    function automatic logic [7:0] random_alnum();
        int n;
        n = $urandom_range(61);
        return (n < 52) ? random_letter() : 8'h30 + 8'(n - 52);
    endfunction

    task automatic send_byte(input logic [7:0] c, input logic eoi);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            text_ch.valid        <= 1'b0;
            text_ch.ch           <= 8'($urandom_range(255));
            text_ch.end_of_input <= 1'($urandom_range(1));
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
        text_ch.valid        <= 1'b1;
        text_ch.ch           <= c;
        text_ch.end_of_input <= eoi;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        bytes_sent++;
        if (eoi)
            markers_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i], 1'b0);
        end
    endtask

    task automatic send_run(input logic [7:0] c, input int n);
        repeat (n) send_byte(c, 1'b0);
    endtask

    task automatic send_marker();
        send_byte(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic send_random_token();
        logic [7:0] tok [$];
        logic [7:0] c;
        string      kw;
        int         pick;
        int         n;
        int         i;
        pick = $urandom_range(99);
        kw = keyword_list[$urandom_range(NUM_KEYS - 1)];
        for (i = 0; i < kw.len(); i++)
        begin
            tok.push_back(kw[i]);
        end
        if (pick >= 45 && pick < 65)
        begin
            i = $urandom_range(tok.size() - 1);
            case ($urandom_range(3))
                0: tok[i] = random_alnum();
                1: tok.push_back(random_alnum());
                2: void'(tok.pop_back());
                default: tok[i] = tok[i] ^ 8'h20;
            endcase
        end
        else if (pick >= 65 && pick < 85)
        begin
            tok.delete();
            n = (pick < 82) ? $urandom_range(1, 12) : $urandom_range(95, 110);
            tok.push_back(random_letter());
            for (i = 1; i < n; i++)
            begin
                tok.push_back(random_alnum());
            end
        end
        else if (pick >= 85)
        begin
            n = $urandom_range(1, 3);
            repeat (n) send_byte(8'($urandom_range(255)), 1'b0);
            return;
        end
        foreach (tok[j])
        begin
            send_byte(tok[j], 1'b0);
        end
        phase_items += tok.size() + 1;
        if ($urandom_range(6) == 0)
        begin
            send_marker();
        end
        else
        begin
            do
                c = 8'($urandom_range(255));
            while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                   (c >= 8'h61 && c <= 8'h7A));
            send_byte(c, 1'b0);
        end
    endtask

    initial
    begin
        int guard;
        rst_n                = 1'b0;
        drained              <= 1'b0;
        text_ch.valid        <= 1'b0;
        text_ch.ch           <= 8'h00;
        text_ch.end_of_input <= 1'b0;
        idle_pct             <= 0;
        stall_pct            <= 0;
        bytes_sent   = 0;
        markers_sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        send_marker();
        for (int k = 0; k < NUM_KEYS; k++)
        begin
            send_text(keyword_list[k]);
            if (k < 10)
                send_byte(directed_seps[k], 1'b0);
        end
        send_marker();

        send_text("9auto autos Auto auto1 continuex unsigne Zz09az a ");
        send_byte(8'h78, 1'b1);
        send_run(8'h61, 100);
        send_text("void ");
        send_marker();

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct    <= idle_plan[ph];
            stall_pct   <= stall_plan[ph];
            phase_items = 0;
            while (phase_items < ITEMS_PER_PHASE)
                send_random_token();
            send_marker();
        end
        text_ch.valid <= 1'b0;

        guard = 0;
        @(negedge clk);
        while (pending != 0 && guard < 50000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (40) @(negedge clk);
        drained <= 1'b1;
        repeat (3) @(negedge clk);

        $display("Sent %0d text bytes with %0d end-of-input markers over directed words,",
                 bytes_sent, markers_sent);
        $display("a split at the word length limit and four pacing phases; checked %0d reports.",
                 checked);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[keyword_occurrence_counter_top.f]
rtl/kocnt_pkg.sv
rtl/kocnt_in_if.sv
rtl/kocnt_out_if.sv
rtl/kocnt_front.sv
rtl/kocnt_fifo.sv
rtl/kocnt_back.sv
rtl/keyword_occurrence_counter_top.sv
sim/kocnt_checker.sv
sim/tb.sv
